@@ hdl/aar_pkg.sv @@
// Shared types and constants of the argmax/argmin axis reduction block.
// Used by aar_seq, aar_table, aar_update and argmax_argmin_axis_reduce.
// No dependencies.
package aar_pkg;

    // Default sizes of the reduced axis and of the inner table
    localparam int AXIS_MAX_DEF  = 4096;
    localparam int INNER_MAX_DEF = 1024;

    // Fixed field widths
    localparam int SAMPLE_W    = 32;
    localparam int INDEX_W     = 12;
    localparam int AXIS_LEN_W  = 13;
    localparam int INNER_LEN_W = 11;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_DATA_W  = 48;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIND_MINIMUM = 2'd0,
        CFG_TIE_LAST     = 2'd1,
        CFG_AXIS_LENGTH  = 2'd2,
        CFG_INNER_LENGTH = 2'd3
    } cfg_reg_t;

    // Compare mode handed to the update stage
    typedef struct packed {
        logic find_minimum;
        logic tie_last;
    } cmp_mode_t;

    // Position flags of one word, decided at accept time
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic last_inner;
    } step_flags_t;

    // Status of the update stage
    typedef struct packed {
        logic busy;
        logic res_pending;
    } upd_status_t;

endpackage

@@ hdl/aar_seq.sv @@
// Configuration registers and the axis/inner position counters.
// Produces the table slot, axis index and position flags of each accepted word.
// Depends on aar_pkg.
module aar_seq #(
    parameter int AXIS_MAX  = aar_pkg::AXIS_MAX_DEF,
    parameter int INNER_MAX = aar_pkg::INNER_MAX_DEF,
    parameter int AW        = $clog2(AXIS_MAX),
    parameter int IW        = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [aar_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [aar_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             accept,
    output aar_pkg::cmp_mode_t               mode,
    output logic [IW-1:0]                    slot,
    output logic [AW-1:0]                    axis_pos,
    output aar_pkg::step_flags_t             flags
);
    import aar_pkg::*;

    logic                   find_minimum_reg;
    logic                   tie_last_reg;
    logic [AXIS_LEN_W-1:0]  axis_length_reg;
    logic [INNER_LEN_W-1:0] inner_length_reg;
    logic [AW-1:0]          axis_pos_reg, axis_pos_next;
    logic [IW-1:0]          inner_pos_reg, inner_pos_next;
    logic [AW:0]            alen;
    logic [IW:0]            ilen;
    logic                   last_row;
    logic                   last_inner;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            find_minimum_reg <= 1'b0;
            tie_last_reg     <= 1'b0;
            axis_length_reg  <= AXIS_LEN_W'(1);
            inner_length_reg <= INNER_LEN_W'(1);
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                CFG_FIND_MINIMUM: find_minimum_reg <= cfg_wdata[0];
                CFG_TIE_LAST:     tie_last_reg     <= cfg_wdata[0];
                CFG_AXIS_LENGTH:  axis_length_reg  <= cfg_wdata[AXIS_LEN_W-1:0];
                CFG_INNER_LENGTH: inner_length_reg <= cfg_wdata[INNER_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp lengths: zero acts as one, oversize acts as the maximum
    always_comb begin
        if (axis_length_reg == '0) begin
            alen = (AW+1)'(1);
        end else if (32'(axis_length_reg) > 32'(AXIS_MAX)) begin
            alen = (AW+1)'(AXIS_MAX);
        end else begin
            alen = (AW+1)'(axis_length_reg);
        end
        if (inner_length_reg == '0) begin
            ilen = (IW+1)'(1);
        end else if (32'(inner_length_reg) > 32'(INNER_MAX)) begin
            ilen = (IW+1)'(INNER_MAX);
        end else begin
            ilen = (IW+1)'(inner_length_reg);
        end
    end

    // Position flags; a counter past a shortened length acts as the last one
    assign last_row   = ({1'b0, axis_pos_reg} + (AW+1)'(1)) >= alen;
    assign last_inner = ({1'b0, inner_pos_reg} + (IW+1)'(1)) >= ilen;

    always_comb begin
        if (last_inner) begin
            inner_pos_next = '0;
            axis_pos_next  = last_row ? '0 : axis_pos_reg + AW'(1);
        end else begin
            inner_pos_next = inner_pos_reg + IW'(1);
            axis_pos_next  = axis_pos_reg;
        end
    end

    // Advance counters on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_pos_reg  <= '0;
            inner_pos_reg <= '0;
        end else if (accept) begin
            axis_pos_reg  <= axis_pos_next;
            inner_pos_reg <= inner_pos_next;
        end
    end

    assign mode.find_minimum = find_minimum_reg;
    assign mode.tie_last     = tie_last_reg;
    assign slot              = inner_pos_reg;
    assign axis_pos          = axis_pos_reg;
    assign flags.first_row   = (axis_pos_reg == '0);
    assign flags.last_row    = last_row;
    assign flags.last_inner  = last_inner;

endmodule

@@ hdl/aar_table.sv @@
// Running best table: one write port and one read port with registered data.
// A read of the entry written at the same edge returns the old contents.
// Depends on aar_pkg for its default sizes.
module aar_table #(
    parameter int DEPTH = aar_pkg::INNER_MAX_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DATA_W = aar_pkg::SAMPLE_W + $clog2(aar_pkg::AXIS_MAX_DEF)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);
    import aar_pkg::*;

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write the updated best
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/aar_update.sv @@
// Compare-and-update stage: merges the table read with a same-entry bypass,
// picks the new best and writes it back. Depends on aar_pkg.
module aar_update #(
    parameter int AXIS_MAX  = aar_pkg::AXIS_MAX_DEF,
    parameter int INNER_MAX = aar_pkg::INNER_MAX_DEF,
    parameter int AW        = $clog2(AXIS_MAX),
    parameter int IW        = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1,
    parameter int DW        = aar_pkg::SAMPLE_W + AW
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic signed [aar_pkg::SAMPLE_W-1:0] sample,
    input  logic [IW-1:0]                     slot,
    input  logic [AW-1:0]                     axis_pos,
    input  aar_pkg::step_flags_t              flags,
    input  aar_pkg::cmp_mode_t                mode,
    input  logic                              out_free,
    output logic                              in_ready,
    output aar_pkg::upd_status_t              status,
    input  logic [DW-1:0]                     rd_data,
    output logic                              wr_en,
    output logic [IW-1:0]                     wr_addr,
    output logic [DW-1:0]                     wr_data,
    output logic                              res_load,
    output logic [aar_pkg::INDEX_W-1:0]       res_index,
    output logic signed [aar_pkg::SAMPLE_W-1:0] res_value,
    output logic                              res_last
);
    import aar_pkg::*;

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [IW-1:0]              s1_slot_reg;
    logic [AW-1:0]              s1_axis_reg;
    step_flags_t                s1_flags_reg;
    logic                       fwd_reg;
    logic signed [SAMPLE_W-1:0] byp_value_reg;
    logic [AW-1:0]              byp_index_reg;

    logic signed [SAMPLE_W-1:0] best_value;
    logic [AW-1:0]              best_index;
    logic                       better;
    logic                       s1_adv;
    logic signed [SAMPLE_W-1:0] new_value;
    logic [AW-1:0]              new_index;

    // Stage advances unless its result cannot enter the output register
    assign s1_adv   = !s1_flags_reg.last_row || out_free;
    assign in_ready = !s1_valid_reg || s1_adv;

    // Take stored best, or the value just written to the same entry
    assign best_value = fwd_reg ? byp_value_reg : signed'(rd_data[SAMPLE_W-1:0]);
    assign best_index = fwd_reg ? byp_index_reg : rd_data[DW-1:SAMPLE_W];

    // Compare candidate against running best
    always_comb begin
        if (mode.find_minimum) begin
            better = mode.tie_last ? (s1_sample_reg <= best_value)
                                   : (s1_sample_reg <  best_value);
        end else begin
            better = mode.tie_last ? (s1_sample_reg >= best_value)
                                   : (s1_sample_reg >  best_value);
        end
    end

    // Pick the new best; the first row loads the entry
    always_comb begin
        if (s1_flags_reg.first_row || better) begin
            new_value = s1_sample_reg;
            new_index = s1_flags_reg.first_row ? '0 : s1_axis_reg;
        end else begin
            new_value = best_value;
            new_index = best_index;
        end
    end

    // Hold stage contents, load on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
            fwd_reg      <= s1_valid_reg && (slot == s1_slot_reg);
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg <= sample;
            s1_slot_reg   <= slot;
            s1_axis_reg   <= axis_pos;
            s1_flags_reg  <= flags;
            byp_value_reg <= new_value;
            byp_index_reg <= new_index;
        end
    end

    // Write back as the word leaves the stage
    assign wr_en   = s1_valid_reg && s1_adv;
    assign wr_addr = s1_slot_reg;
    assign wr_data = {new_index, new_value};

    assign res_load  = wr_en && s1_flags_reg.last_row;
    assign res_index = INDEX_W'(new_index);
    assign res_value = new_value;
    assign res_last  = s1_flags_reg.last_inner;

    assign status.busy        = s1_valid_reg;
    assign status.res_pending = s1_valid_reg && s1_flags_reg.last_row;

endmodule

@@ hdl/argmax_argmin_axis_reduce.sv @@
// Streaming argmax/argmin along one tensor axis: top level.
// Instantiates aar_seq, aar_table and aar_update; depends on aar_pkg.
//
// Usage:
//   s_axis carries one signed 32-bit tensor element per word in row-major
//   order (outer slice, axis position, inner position). m_axis returns one
//   word per element of the last axis row: tdata holds best_index in bits
//   [11:0] and best_value in [43:12]; tlast marks the last word of a slice.
//   Program find_minimum, tie_last, axis_length and inner_length through
//   cfg_we/cfg_index/cfg_wdata while the stream is idle.
// Pipeline:
//   One element per cycle unless a result waits on a stalled output. Each
//   word reads its table entry at accept, compares in the next cycle and
//   writes back as it leaves; a bypass register covers back-to-back words on
//   the same entry. A last-row word loads the output register as it leaves.
// Reset:
//   aresetn clears the counters, configuration (maximum, first index, lengths
//   of one) and the output register; the first axis row loads the table.
// Stall:
//   The output register holds a result while m_axis_tready is low; input keeps
//   flowing until a further result would have to enter it.
module argmax_argmin_axis_reduce #(
    parameter int AXIS_MAX  = aar_pkg::AXIS_MAX_DEF,
    parameter int INNER_MAX = aar_pkg::INNER_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [aar_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [aar_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [aar_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [31:0] sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [aar_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [11:0] best_index,
                                                             // [43:12] best_value
    output logic                              m_axis_tlast   // slice_done
);
    import aar_pkg::*;

    localparam int AW = $clog2(AXIS_MAX);
    localparam int IW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
    localparam int DW = SAMPLE_W + AW;

    logic                       accept;
    cmp_mode_t                  mode;
    logic [IW-1:0]              slot;
    logic [AW-1:0]              axis_pos;
    step_flags_t                flags;
    logic                       out_free;
    logic                       in_ready;
    upd_status_t                status;
    logic [DW-1:0]              rd_data;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    logic [DW-1:0]              wr_data;
    logic                       res_load;
    logic [INDEX_W-1:0]         res_index;
    logic signed [SAMPLE_W-1:0] res_value;
    logic                       res_last;

    logic                       m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]         m_index_reg;
    logic [SAMPLE_W-1:0]        m_value_reg;
    logic                       m_last_reg;

    assign accept        = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    aar_seq #(
        .AXIS_MAX  (AXIS_MAX),
        .INNER_MAX (INNER_MAX)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .mode      (mode),
        .slot      (slot),
        .axis_pos  (axis_pos),
        .flags     (flags)
    );

    aar_table #(
        .DEPTH  (INNER_MAX),
        .ADDR_W (IW),
        .DATA_W (DW)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (slot),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    aar_update #(
        .AXIS_MAX  (AXIS_MAX),
        .INNER_MAX (INNER_MAX)
    ) u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .sample    (signed'(s_axis_tdata)),
        .slot      (slot),
        .axis_pos  (axis_pos),
        .flags     (flags),
        .mode      (mode),
        .out_free  (out_free),
        .in_ready  (in_ready),
        .status    (status),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_load  (res_load),
        .res_index (res_index),
        .res_value (res_value),
        .res_last  (res_last)
    );

    // Output register: load a result, drop it once taken
    always_comb begin
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_index_reg <= res_index;
            m_value_reg <= res_value;
            m_last_reg  <= res_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - INDEX_W - SAMPLE_W)'(0), m_value_reg, m_index_reg};
    assign m_axis_tlast  = m_last_reg;

    // A held result is never overwritten
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !res_load)
        else $error("result loaded over a stalled output word");

    // A result waiting behind a stalled output blocks the input
    a_stall_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready && status.res_pending |-> !s_axis_tready)
        else $error("input accepted while a result cannot move");

    // Every loaded result shows on the output next cycle
    a_load_shows : assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // Table is written only by a word that is in the update stage
    a_write_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> status.busy)
        else $error("table write without a word in the update stage");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the argmax/argmin axis reduction block.
// Drives tensor words with random gaps and stalls and checks every result word
// against a hand-typed or predicted running extreme table; depends on aar_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aar_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_WORDS   = 320;
    localparam int OVERSIZE_WORDS = 40;
    localparam int TABLE_ROWS     = 34;

    typedef struct packed {
        logic [INDEX_W-1:0]  idx;
        logic [SAMPLE_W-1:0] val;
        logic                last;
    } result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_DATA,
        ROW_CHECK
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        cfg_reg_t            sel;
        logic [12:0]         wval;
        logic [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]  e_idx;
        logic [SAMPLE_W-1:0] e_val;
        logic                e_last;
    } stim_row_t;

    // Directed rows: ROW_CHECK carries a result typed in by hand, ROW_DATA is predicted
    localparam stim_row_t STIM_TABLE [TABLE_ROWS] = '{
        // after reset: one position along the axis, one inner position, maximum
        '{ROW_CHECK, CFG_FIND_MINIMUM, 13'd0, 32'h7FFF_FFFF, 12'd0, 32'h7FFF_FFFF, 1'b1},
        '{ROW_CHECK, CFG_FIND_MINIMUM, 13'd0, 32'h8000_0000, 12'd0, 32'h8000_0000, 1'b1},
        // zero lengths act as one
        '{ROW_CFG,   CFG_AXIS_LENGTH,  13'd0, 32'h0,         12'd0, 32'h0,         1'b0},
        '{ROW_CHECK, CFG_FIND_MINIMUM, 13'd0, 32'hFFFF_FFFF, 12'd0, 32'hFFFF_FFFF, 1'b1},
        '{ROW_CFG,   CFG_INNER_LENGTH, 13'd0, 32'h0,         12'd0, 32'h0,         1'b0},
        '{ROW_CHECK, CFG_FIND_MINIMUM, 13'd0, 32'h0,         12'd0, 32'h0,         1'b1},
        // maximum with ties kept at the first index
        '{ROW_CFG,   CFG_AXIS_LENGTH,  13'd3, 32'h0,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'h5,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'h7FFF_FFFF, 12'd0, 32'h0,         1'b0},
        '{ROW_CHECK, CFG_FIND_MINIMUM, 13'd0, 32'h7FFF_FFFF, 12'd1, 32'h7FFF_FFFF, 1'b1},
        // maximum with ties going to the last index
        '{ROW_CFG,   CFG_TIE_LAST,     13'd1, 32'h0,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'h5,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'h7FFF_FFFF, 12'd0, 32'h0,         1'b0},
        '{ROW_CHECK, CFG_FIND_MINIMUM, 13'd0, 32'h7FFF_FFFF, 12'd2, 32'h7FFF_FFFF, 1'b1},
        // minimum, ties to the last index
        '{ROW_CFG,   CFG_FIND_MINIMUM, 13'd1, 32'h0,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'h8000_0000, 12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'h8000_0000, 12'd0, 32'h0,         1'b0},
        '{ROW_CHECK, CFG_FIND_MINIMUM, 13'd0, 32'h3,         12'd1, 32'h8000_0000, 1'b1},
        // minimum, ties to the first index
        '{ROW_CFG,   CFG_TIE_LAST,     13'd0, 32'h0,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'h8000_0000, 12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'h8000_0000, 12'd0, 32'h0,         1'b0},
        '{ROW_CHECK, CFG_FIND_MINIMUM, 13'd0, 32'h0,         12'd0, 32'h8000_0000, 1'b1},
        // two inner positions, two axis rows
        '{ROW_CFG,   CFG_FIND_MINIMUM, 13'd0, 32'h0,         12'd0, 32'h0,         1'b0},
        '{ROW_CFG,   CFG_AXIS_LENGTH,  13'd2, 32'h0,         12'd0, 32'h0,         1'b0},
        '{ROW_CFG,   CFG_INNER_LENGTH, 13'd2, 32'h0,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'd10,        12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'hFFFF_FFFD, 12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'd7,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'hFFFF_FFF7, 12'd0, 32'h0,         1'b0},
        // shrink the inner length in the middle of the last axis row
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'd1,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'd2,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'd4,         12'd0, 32'h0,         1'b0},
        '{ROW_CFG,   CFG_INNER_LENGTH, 13'd1, 32'h0,         12'd0, 32'h0,         1'b0},
        '{ROW_DATA,  CFG_FIND_MINIMUM, 13'd0, 32'd6,         12'd0, 32'h0,         1'b0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Predicted state of the block
    logic                  cfg_min;
    logic                  cfg_last;
    logic [AXIS_LEN_W-1:0] cfg_axis_len;
    logic [INNER_LEN_W-1:0] cfg_inner_len;
    logic [SAMPLE_W-1:0]   best_val [INNER_MAX_DEF];
    logic [INDEX_W-1:0]    best_idx [INNER_MAX_DEF];
    bit                    slot_loaded [INNER_MAX_DEF];
    logic [11:0]           axis_pos;
    logic [9:0]            inner_pos;

    result_t expected_results [$];
    int      error_count;
    int      cycle_count;
    int      sample_count;
    bit      s_burst;
    bit      m_burst;

    argmax_argmin_axis_reduce u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** argmax_argmin_axis_reduce: FAILED **");
            $finish;
        end
    end

    function automatic int eff_len(input int v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Candidate replaces the stored extreme under the current compare mode
    function automatic bit wins_over(input logic signed [SAMPLE_W-1:0] cand,
                                     input logic signed [SAMPLE_W-1:0] held);
        if (cfg_min) return cfg_last ? (cand <= held) : (cand < held);
        return cfg_last ? (cand >= held) : (cand > held);
    endfunction

    // A new inner length must not make the block read a never-loaded slot
    function automatic bit inner_write_safe(input logic [12:0] wv);
        int n;
        n = eff_len(int'(wv[INNER_LEN_W-1:0]), INNER_MAX_DEF);
        if (axis_pos == 0) return 1'b1;
        for (int s = 0; s < n; s++) begin
            if (!slot_loaded[s]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return SAMPLE_W'($urandom_range(0, 4)) - 32'd2;
            4, 5: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Fold one accepted word into the predicted table and queue its result
    task automatic fold_sample(input logic [SAMPLE_W-1:0] raw, input bit typed,
                               input result_t typed_res);
        int      alen;
        int      ilen;
        int      slot;
        bit      last_row;
        bit      last_inner;
        result_t r;
        alen       = eff_len(int'(cfg_axis_len), AXIS_MAX_DEF);
        ilen       = eff_len(int'(cfg_inner_len), INNER_MAX_DEF);
        slot       = int'(inner_pos) % INNER_MAX_DEF;
        last_row   = (int'(axis_pos) + 1 >= alen);
        last_inner = (int'(inner_pos) + 1 >= ilen);
        if (axis_pos == 0) begin
            best_val[slot]    = raw;
            best_idx[slot]    = '0;
            slot_loaded[slot] = 1'b1;
        end else if (wins_over(raw, best_val[slot])) begin
            best_val[slot] = raw;
            best_idx[slot] = axis_pos;
        end
        if (last_row) begin
            r.idx  = best_idx[slot];
            r.val  = best_val[slot];
            r.last = last_inner;
            expected_results.insert(expected_results.size(), typed ? typed_res : r);
        end
        if (last_inner) begin
            inner_pos = '0;
            axis_pos  = last_row ? 12'd0 : axis_pos + 12'd1;
        end else begin
            inner_pos = inner_pos + 10'd1;
        end
    endtask

    // Send one word after a random gap and fold it in once accepted
    task automatic push_sample(input logic [SAMPLE_W-1:0] raw, input bit typed,
                               input result_t typed_res);
        int gap;
        gap = s_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        do @(posedge aclk); while (!s_axis_tready);
        sample_count++;
        fold_sample(raw, typed, typed_res);
    endtask

    // Hold off the input until every pending result is out and the pipe is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_reg_t sel, input logic [12:0] wv);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= wv;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        case (sel)
            CFG_FIND_MINIMUM: cfg_min       = wv[0];
            CFG_TIE_LAST:     cfg_last      = wv[0];
            CFG_AXIS_LENGTH:  cfg_axis_len  = wv[AXIS_LEN_W-1:0];
            CFG_INNER_LENGTH: cfg_inner_len = wv[INNER_LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Run the counters back to the start of a slice
    task automatic finish_slice();
        while (axis_pos != 0 || inner_pos != 0) push_sample(draw_sample(), 1'b0, '0);
    endtask

    // Accept result words with random stalls and check them in order
    task automatic collect_results();
        result_t want;
        logic [INDEX_W-1:0]  got_idx;
        logic [SAMPLE_W-1:0] got_val;
        logic                got_last;
        int                  gap;
        forever begin
            gap = m_burst ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            got_idx  = m_axis_tdata[INDEX_W-1:0];
            got_val  = m_axis_tdata[INDEX_W+SAMPLE_W-1:INDEX_W];
            got_last = m_axis_tlast;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word idx %0d value %h last %0b",
                                          got_idx, got_val, got_last));
            end else begin
                want = expected_results.pop_front();
                if (got_idx !== want.idx)
                    report_mismatch($sformatf("best_index %0d, want %0d", got_idx, want.idx));
                if (got_val !== want.val)
                    report_mismatch($sformatf("best_value %h, want %h", got_val, want.val));
                if (got_last !== want.last)
                    report_mismatch($sformatf("slice_done %0b, want %0b", got_last, want.last));
            end
        end
    endtask

    initial begin
        int          n;
        int          alen;
        int          ilen;
        int          start;
        bit          broken;
        logic [12:0] wv;
        stim_row_t   row;

        error_count   = 0;
        cycle_count   = 0;
        sample_count  = 0;
        s_burst       = 1'b0;
        m_burst       = 1'b0;
        cfg_min       = 1'b0;
        cfg_last      = 1'b0;
        cfg_axis_len  = AXIS_LEN_W'(1);
        cfg_inner_len = INNER_LEN_W'(1);
        axis_pos      = '0;
        inner_pos     = '0;
        for (int s = 0; s < INNER_MAX_DEF; s++) slot_loaded[s] = 1'b0;

        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        fork
            collect_results();
        join_none

        // Directed table
        for (int i = 0; i < TABLE_ROWS; i++) begin
            row = STIM_TABLE[i];
            case (row.kind)
                ROW_CFG: begin
                    settle();
                    cfg_write(row.sel, row.wval);
                end
                ROW_DATA:  push_sample(row.sample, 1'b0, '0);
                default:   push_sample(row.sample, 1'b1, '{row.e_idx, row.e_val, row.e_last});
            endcase
        end

        // Random phases: short shapes, mostly whole slices, some cut mid-slice
        start = sample_count;
        while (sample_count - start < RANDOM_WORDS) begin
            settle();
            s_burst = ($urandom_range(0, 3) == 0);
            m_burst = ($urandom_range(0, 3) == 0);
            cfg_write(CFG_FIND_MINIMUM, 13'($urandom));
            cfg_write(CFG_TIE_LAST, 13'($urandom));
            wv = ($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
            cfg_write(CFG_AXIS_LENGTH, wv);
            wv = ($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom_range(1, 8));
            if ($urandom_range(0, 3) == 0) wv[12:11] = 2'($urandom);
            if (inner_write_safe(wv)) cfg_write(CFG_INNER_LENGTH, wv);
            alen   = eff_len(int'(cfg_axis_len), AXIS_MAX_DEF);
            ilen   = eff_len(int'(cfg_inner_len), INNER_MAX_DEF);
            broken = ($urandom_range(0, 4) == 0);
            n = broken ? $urandom_range(1, alen * ilen + 3)
                       : $urandom_range(1, 3) * alen * ilen;
            repeat (n) push_sample(draw_sample(), 1'b0, '0);
            if ($urandom_range(0, 3) != 0) finish_slice();
        end
        finish_slice();

        // Oversized axis length: no row ends early; then shrink it under the counter
        settle();
        s_burst = 1'b0;
        m_burst = 1'b0;
        cfg_write(CFG_FIND_MINIMUM, 13'($urandom));
        cfg_write(CFG_TIE_LAST, 13'($urandom));
        cfg_write(CFG_INNER_LENGTH, 13'd1);
        cfg_write(CFG_AXIS_LENGTH, 13'h1FFF);
        repeat (OVERSIZE_WORDS) push_sample($urandom, 1'b0, '0);
        settle();
        cfg_write(CFG_AXIS_LENGTH, 13'd1);
        push_sample(draw_sample(), 1'b0, '0);

        // Oversized inner length: no slice ends early; then shrink it under the counter
        settle();
        cfg_write(CFG_INNER_LENGTH, 13'd2047);
        repeat (OVERSIZE_WORDS) push_sample(draw_sample(), 1'b0, '0);
        settle();
        cfg_write(CFG_INNER_LENGTH, 13'd1);
        push_sample(draw_sample(), 1'b0, '0);

        settle();
        if (error_count == 0) begin
            $display("** argmax_argmin_axis_reduce: PASSED **");
        end else begin
            $display("** argmax_argmin_axis_reduce: FAILED **");
        end
        $finish;
    end

endmodule
